// File: hdl/bounded_array_list_engine_macros.svh
// Assertion macros used by the checker file.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BALE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BALE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/bale_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types and constants of the bounded array list engine.
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int WORD_W        = 32;

  typedef enum logic [2:0] {
    ACT_PUSH_END   = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_INSERT     = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_END    = 3'd4,
    ACT_READ       = 3'd5,
    ACT_WRITE      = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_HOLD       = 2'd0,
    MODE_OPEN       = 2'd1,
    MODE_WRITE      = 2'd2,
    MODE_SHIFT_DOWN = 2'd3
  } cell_mode_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_mode_t          mode;
    logic [WORD_W-1:0]   word;
  } cell_cmd_t;

  // Result control from the request decoder.
  typedef struct packed {
    status_t status;
    logic    take_read;
  } req_result_t;

endpackage

// File: hdl/bale_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_cell
// One list entry: holds a word, loads from its lower or upper neighbor,
// or takes the broadcast word, as the command says.
// ----------------------------------------------------------------------------
module bale_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 6
) (
  input  logic                       clk,
  input  bale_pkg::cell_cmd_t        cmd,
  input  logic [IW-1:0]              idx,
  input  logic [IW-1:0]              rd_idx,
  input  logic [bale_pkg::WORD_W-1:0] left_word,
  input  logic [bale_pkg::WORD_W-1:0] right_word,
  output logic [bale_pkg::WORD_W-1:0] word,
  output logic [bale_pkg::WORD_W-1:0] rd_word
);
  import bale_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [WORD_W-1:0] word_next;

  always_comb begin
    word_next = word;
    case (cmd.mode)
      MODE_OPEN: begin
        // take the new word at the slot, shift up above it
        if (MY_IDX == idx) begin
          word_next = cmd.word;
        end else if (MY_IDX > idx) begin
          word_next = left_word;
        end
      end
      MODE_WRITE: begin
        if (MY_IDX == idx) begin
          word_next = cmd.word;
        end
      end
      MODE_SHIFT_DOWN: word_next = right_word;
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  assign rd_word = (rd_idx == MY_IDX) ? word : '0;

endmodule

// File: hdl/bale_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_ctrl
// Request decoder: checks bounds against the count, repairs indexes and
// builds the command for the cell chain and the result control.
// ----------------------------------------------------------------------------
module bale_ctrl #(
  parameter int DEPTH = bale_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic                        go,
  input  logic [2:0]                  action,
  input  logic signed [7:0]           position,
  input  logic [bale_pkg::WORD_W-1:0] value,
  input  logic [CW-1:0]               count,
  output bale_pkg::cell_cmd_t         cmd,
  output logic [IW-1:0]               idx,
  output logic [IW-1:0]               rd_idx,
  output bale_pkg::req_result_t       res,
  output logic [CW-1:0]               count_next
);
  import bale_pkg::*;

  localparam int CMPW = (CW > 8) ? CW : 8;

  logic            full;
  logic            empty;
  logic            pos_neg;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [IW-1:0]   pos_idx;
  logic [IW-1:0]   cnt_idx;
  logic [IW-1:0]   last_idx;
  logic [WORD_W-1:0] fill_word;
  action_t         act;

  assign act       = action_t'(action);
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pos_neg   = position[7];
  assign pos_ext   = CMPW'(position[6:0]);
  assign cnt_ext   = CMPW'(count);
  assign pos_idx   = IW'(position[6:0]);
  assign cnt_idx   = IW'(count);
  assign last_idx  = IW'(count - CW'(1));
  assign fill_word = (act == ACT_WRITE) ? value : '0;

  always_comb begin
    cmd.mode      = MODE_HOLD;
    cmd.word      = value;
    idx           = '0;
    rd_idx        = '0;
    res.status    = ST_OK;
    res.take_read = 1'b0;
    count_next    = count;
    case (act)
      ACT_PUSH_END, ACT_PUSH_FRONT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          cmd.mode   = MODE_OPEN;
          idx        = (act == ACT_PUSH_END) ? cnt_idx : '0;
          count_next = count + CW'(1);
        end
      end
      ACT_INSERT: begin
        if (pos_neg || (pos_ext > cnt_ext)) begin
          res.status = ST_BADPOS;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          cmd.mode   = MODE_OPEN;
          idx        = pos_idx;
          count_next = count + CW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          cmd.mode      = MODE_SHIFT_DOWN;
          res.take_read = 1'b1;
          count_next    = count - CW'(1);
        end
      end
      ACT_POP_END: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          rd_idx        = last_idx;
          res.take_read = 1'b1;
          count_next    = count - CW'(1);
        end
      end
      ACT_READ, ACT_WRITE: begin
        if (pos_neg || (pos_ext >= cnt_ext)) begin
          // repair: push a zero (or the written word) at the front or end;
          // a repaired read always returns zero
          if (full) begin
            res.status = ST_FULL;
          end else begin
            cmd.mode   = MODE_OPEN;
            cmd.word   = fill_word;
            idx        = pos_neg ? '0 : cnt_idx;
            count_next = count + CW'(1);
          end
        end else if (act == ACT_READ) begin
          rd_idx        = pos_idx;
          res.take_read = 1'b1;
        end else begin
          cmd.mode = MODE_WRITE;
          idx      = pos_idx;
        end
      end
      default: ;
    endcase
    if (!go) begin
      cmd.mode   = MODE_HOLD;
      count_next = count;
    end
  end

endmodule

// File: hdl/bounded_array_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Ordered list of up to DEPTH signed words held in a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: action, position,
//   value. Output channel (out_valid/out_ready) returns one result per
//   request: result_word, length, status.
//   Every request is decoded against the entry count and applied to all
//   cells in the cycle it is accepted; every cell loads from its neighbor at
//   once, so shifts cost nothing extra. The result is registered and shows
//   in the cycle after acceptance.
//   Throughput: one request per cycle. The only limit is the single output
//   register: in_ready is high while it is empty or being taken.
//   A stalled receiver holds the result and blocks new requests until it is
//   taken; the list is not touched meanwhile.
//   Reset clears the count and the output valid; entries are not cleared,
//   and no request can read an entry at or above the count.
// ----------------------------------------------------------------------------
module bounded_array_list_engine #(
  parameter int DEPTH = bale_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  action,
  input  logic signed [7:0]           position,
  input  logic signed [bale_pkg::WORD_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [bale_pkg::WORD_W-1:0] result_word,
  output logic [CW-1:0]               length,
  output logic [1:0]                  status
);
  import bale_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic              accept;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  cell_cmd_t         cmd;
  req_result_t       res;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     rd_idx;
  logic [WORD_W-1:0] words    [DEPTH];
  logic [WORD_W-1:0] rd_words [DEPTH];
  logic [WORD_W-1:0] rd_bus;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  bale_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .IW    (IW)
  ) u_ctrl (
    .go         (accept),
    .action     (action),
    .position   (position),
    .value      (value),
    .count      (count),
    .cmd        (cmd),
    .idx        (idx),
    .rd_idx     (rd_idx),
    .res        (res),
    .count_next (count_next)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    bale_cell #(
      .INDEX (i),
      .IW    (IW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (idx),
      .rd_idx     (rd_idx),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i]),
      .rd_word    (rd_words[i])
    );
  end

  // each cell drives zero unless selected
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | rd_words[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_word <= res.take_read ? rd_bus : '0;
      length      <= count_next;
      status      <= res.status;
    end
  end

endmodule

// File: hdl/bale_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bale_checker
// Port-level checks of the bounded array list engine, bound to the top.
// ----------------------------------------------------------------------------
`include "bounded_array_list_engine_macros.svh"

module bale_checker #(
  parameter int DEPTH = bale_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [bale_pkg::WORD_W-1:0] result_word,
  input logic [CW-1:0]               length,
  input logic [1:0]                  status
);
  import bale_pkg::*;

  `BALE_ASSERT_NEXT(a_hold_result, out_valid && !out_ready, out_valid && $stable(result_word) && $stable(length) && $stable(status), "result changed while stalled")
  `BALE_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "not ready with empty output")
  `BALE_ASSERT_NOW(a_length_bound, out_valid, length <= CW'(DEPTH), "length above depth")
  `BALE_ASSERT_NOW(a_refused_zero, out_valid && (status != ST_OK), result_word == '0, "refused item with nonzero word")

endmodule

bind bounded_array_list_engine bale_checker #(.DEPTH(DEPTH), .CW(CW)) u_bale_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded array list engine. A table of
// directed requests (empty, full, repaired indexes, extremes) is followed
// by random grow / shrink / mixed phases. Every result is checked field by
// field against the row's typed expectation or an in-bench mirror of the
// list. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import bale_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEFAULT;
  localparam int LEN_W        = $clog2(LIST_DEPTH + 1);
  localparam int RANDOM_ITEMS = 350;
  localparam int WATCHDOG     = 4000;
  localparam int PRINT_CAP    = 40;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [LEN_W-1:0]         len;
    status_t                  st;
  } reply_t;

  typedef struct {
    logic [2:0]               act;
    logic signed [7:0]        pos;
    logic signed [WORD_W-1:0] val;
    int                       reps;
    bit                       fixed;
    logic signed [WORD_W-1:0] e_word;
    logic [LEN_W-1:0]         e_len;
    status_t                  e_st;
  } stim_row_t;

  typedef enum {PH_GROW, PH_SHRINK, PH_MIX} phase_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               action = '0;
  logic signed [7:0]        position = '0;
  logic signed [WORD_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [WORD_W-1:0] result_word;
  logic [LEN_W-1:0]         length;
  logic [1:0]               status;

  // Mirror of the list contents.
  logic signed [WORD_W-1:0] mirror_words [LIST_DEPTH];
  int                       mirror_len;

  reply_t    pending_replies[$];
  stim_row_t directed_rows[$];

  bit quiet;
  int fault_count;
  int items_sent;
  int replies_seen;
  int peak_len;
  int status_seen [4];
  int idle_cycles;
  int ready_left;
  bit ready_level;

  bounded_array_list_engine i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_word(result_word),
    .length     (length),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Open a slot at index at and fill it; caller checks for room.
  function automatic void open_slot(int at, logic signed [WORD_W-1:0] w);
    for (int i = mirror_len; i > at; i--) mirror_words[i] = mirror_words[i-1];
    mirror_words[at] = w;
    mirror_len++;
  endfunction

  function automatic reply_t list_apply(logic [2:0] act, logic signed [7:0] pos,
                                        logic signed [WORD_W-1:0] val);
    reply_t r;
    int     p;
    int     idx;
    bit     room;
    p      = pos;
    room   = (mirror_len < LIST_DEPTH);
    r.word = '0;
    r.st   = ST_OK;
    idx    = 0;
    case (act)
      ACT_PUSH_END, ACT_PUSH_FRONT: begin
        if (!room) r.st = ST_FULL;
        else open_slot((act == ACT_PUSH_END) ? mirror_len : 0, val);
      end
      ACT_INSERT: begin
        if (p < 0 || p > mirror_len) r.st = ST_BADPOS;
        else if (!room) r.st = ST_FULL;
        else open_slot(p, val);
      end
      ACT_POP_FRONT: begin
        if (mirror_len == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.word = mirror_words[0];
          for (int i = 1; i < mirror_len; i++) mirror_words[i-1] = mirror_words[i];
          mirror_len--;
        end
      end
      ACT_POP_END: begin
        if (mirror_len == 0) begin
          r.st = ST_EMPTY;
        end else begin
          mirror_len--;
          r.word = mirror_words[mirror_len];
        end
      end
      ACT_READ, ACT_WRITE: begin
        // Out-of-range index needs a repair push, refused when full.
        if ((p < 0 || p >= mirror_len) && !room) begin
          r.st = ST_FULL;
        end else begin
          if (p < 0) begin
            open_slot(0, '0);
            idx = 0;
          end else if (p >= mirror_len) begin
            open_slot(mirror_len, '0);
            idx = mirror_len - 1;
          end else begin
            idx = p;
          end
          if (act == ACT_READ) r.word = mirror_words[idx];
          else mirror_words[idx] = val;
        end
      end
      default: ;
    endcase
    r.len = LEN_W'(mirror_len);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(logic [2:0] a, int p, logic [WORD_W-1:0] v, int reps, bit fixed,
                         logic [WORD_W-1:0] ew, int el, status_t es);
    stim_row_t r;
    r.act    = a;
    r.pos    = p[7:0];
    r.val    = v;
    r.reps   = reps;
    r.fixed  = fixed;
    r.e_word = ew;
    r.e_len  = el[LEN_W-1:0];
    r.e_st   = es;
    directed_rows.push_back(r);
  endtask

  task automatic send_item(stim_row_t it);
    int     gap;
    reply_t exp_r;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    action   <= it.act;
    position <= it.pos;
    value    <= it.val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Item taken at this edge: advance the mirror.
    exp_r = list_apply(it.act, it.pos, it.val);
    if (it.fixed) begin
      exp_r.word = it.e_word;
      exp_r.len  = it.e_len;
      exp_r.st   = it.e_st;
    end
    pending_replies.push_back(exp_r);
    items_sent++;
  endtask

  task automatic pick_random(phase_t ph, output stim_row_t it);
    int r;
    int t;
    logic [31:0] raw;
    r = $urandom_range(0, 99);
    case (ph)
      PH_GROW: begin
        if (r < 30)      it.act = ACT_PUSH_END;
        else if (r < 50) it.act = ACT_PUSH_FRONT;
        else if (r < 70) it.act = ACT_INSERT;
        else if (r < 78) it.act = ACT_READ;
        else if (r < 88) it.act = ACT_WRITE;
        else if (r < 92) it.act = ACT_POP_FRONT;
        else if (r < 96) it.act = ACT_POP_END;
        else             it.act = ACT_UNUSED;
      end
      PH_SHRINK: begin
        if (r < 35)      it.act = ACT_POP_FRONT;
        else if (r < 70) it.act = ACT_POP_END;
        else if (r < 78) it.act = ACT_READ;
        else if (r < 86) it.act = ACT_WRITE;
        else if (r < 91) it.act = ACT_INSERT;
        else if (r < 95) it.act = ACT_PUSH_END;
        else if (r < 98) it.act = ACT_PUSH_FRONT;
        else             it.act = ACT_UNUSED;
      end
      default: it.act = 3'($urandom_range(0, 7));
    endcase
    // Position: mostly in range, some negative, past the end or raw.
    r = $urandom_range(0, 9);
    if (r < 6) begin
      t = $urandom_range(0, mirror_len);
    end else if (r == 6) begin
      t = -int'($urandom_range(1, 128));
    end else if (r == 7) begin
      t = $urandom_range(mirror_len, 127);
    end else begin
      raw = $urandom();
      t   = raw;
    end
    it.pos = t[7:0];
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 3))
        0: it.val = 32'h8000_0000;
        1: it.val = 32'h7FFF_FFFF;
        2: it.val = 32'h0000_0000;
        default: it.val = 32'hFFFF_FFFF;
      endcase
    end else begin
      it.val = $urandom();
    end
    it.reps  = 1;
    it.fixed = 1'b0;
  endtask

  // Receiver: bursts of ready and stalls of random length.
  always @(negedge clk) begin
    if (ready_left <= 0) begin
      if ($urandom_range(0, 1) == 1) begin
        ready_level = 1'b1;
        ready_left  = $urandom_range(1, 12);
      end else begin
        ready_level = 1'b0;
        ready_left  = pick_gap();
        if (ready_left < 1) ready_left = 1;
      end
    end
    ready_left--;
    out_ready <= quiet ? 1'b1 : ready_level;
  end

  // Check every result against the oldest expectation.
  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && out_valid && out_ready) begin
      replies_seen++;
      status_seen[status]++;
      if (length > peak_len) peak_len = length;
      if (pending_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= PRINT_CAP)
          $display("%0t: result with nothing expected: word %h length %0d status %0d",
                   $time, result_word, length, status);
      end else begin
        exp_r = pending_replies.pop_front();
        if (result_word !== exp_r.word) begin
          fault_count++;
          if (fault_count <= PRINT_CAP)
            $display("%0t: result_word expected %h actual %h", $time, exp_r.word, result_word);
        end
        if (length !== exp_r.len) begin
          fault_count++;
          if (fault_count <= PRINT_CAP)
            $display("%0t: length expected %0d actual %0d", $time, exp_r.len, length);
        end
        if (status !== exp_r.st) begin
          fault_count++;
          if (fault_count <= PRINT_CAP)
            $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
        end
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG, pending_replies.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    stim_row_t item;
    phase_t    ph;
    int        linger;
    int        mix_left;
    for (int i = 0; i < LIST_DEPTH; i++) mirror_words[i] = '0;
    mirror_len = 0;

    // Directed requests; typed expectations where obvious.
    add_row(ACT_POP_FRONT,  0,    32'h0,         1,  1, 32'h0,         0,  ST_EMPTY);
    add_row(ACT_POP_END,    0,    32'h0,         1,  1, 32'h0,         0,  ST_EMPTY);
    add_row(ACT_INSERT,     -1,   32'h1,         1,  1, 32'h0,         0,  ST_BADPOS);
    add_row(ACT_INSERT,     1,    32'h1,         1,  1, 32'h0,         0,  ST_BADPOS);
    add_row(ACT_INSERT,     0,    32'h7FFF_FFFF, 1,  1, 32'h0,         1,  ST_OK);
    add_row(ACT_PUSH_FRONT, 0,    32'h8000_0000, 1,  1, 32'h0,         2,  ST_OK);
    add_row(ACT_PUSH_END,   0,    32'hFFFF_FFFF, 1,  1, 32'h0,         3,  ST_OK);
    add_row(ACT_READ,       0,    32'h0,         1,  1, 32'h8000_0000, 3,  ST_OK);
    add_row(ACT_READ,       1,    32'h0,         1,  1, 32'h7FFF_FFFF, 3,  ST_OK);
    add_row(ACT_READ,       -128, 32'h0,         1,  1, 32'h0,         4,  ST_OK);
    add_row(ACT_READ,       127,  32'h0,         1,  1, 32'h0,         5,  ST_OK);
    add_row(ACT_WRITE,      -1,   32'h1234_5678, 1,  1, 32'h0,         6,  ST_OK);
    add_row(ACT_WRITE,      100,  32'h0F0F_0F0F, 1,  1, 32'h0,         7,  ST_OK);
    add_row(ACT_INSERT,     3,    32'h55AA_55AA, 1,  0, 32'h0,         0,  ST_OK);
    add_row(ACT_UNUSED,     0,    32'hFFFF_FFFF, 1,  1, 32'h0,         8,  ST_OK);
    add_row(ACT_POP_FRONT,  0,    32'h0,         1,  1, 32'h1234_5678, 7,  ST_OK);
    add_row(ACT_POP_END,    0,    32'h0,         1,  1, 32'h0F0F_0F0F, 6,  ST_OK);
    add_row(ACT_WRITE,      2,    32'h0,         1,  0, 32'h0,         0,  ST_OK);
    add_row(ACT_PUSH_END,   0,    32'h1,         58, 0, 32'h0,         0,  ST_OK);
    add_row(ACT_PUSH_END,   0,    32'h1,         1,  1, 32'h0,         64, ST_FULL);
    add_row(ACT_PUSH_FRONT, 0,    32'h1,         1,  1, 32'h0,         64, ST_FULL);
    add_row(ACT_INSERT,     64,   32'h1,         1,  1, 32'h0,         64, ST_FULL);
    add_row(ACT_INSERT,     127,  32'h1,         1,  1, 32'h0,         64, ST_BADPOS);
    add_row(ACT_READ,       -1,   32'h0,         1,  1, 32'h0,         64, ST_FULL);
    add_row(ACT_WRITE,      64,   32'h2,         1,  1, 32'h0,         64, ST_FULL);
    add_row(ACT_READ,       63,   32'h0,         1,  0, 32'h0,         0,  ST_OK);
    add_row(ACT_POP_END,    0,    32'h0,         64, 0, 32'h0,         0,  ST_OK);
    add_row(ACT_POP_FRONT,  0,    32'h0,         1,  1, 32'h0,         0,  ST_EMPTY);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int k = 0; k < row.reps; k++) begin
        item     = row;
        item.val = row.val + k;
        send_item(item);
      end
    end

    // Random phases: fill to full, drain to empty, then mixed traffic, and round again.
    ph       = PH_GROW;
    linger   = 0;
    mix_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = ((n % 150) < 30);
      case (ph)
        PH_GROW: begin
          if (mirror_len == LIST_DEPTH) linger++;
          if (linger > 8) begin
            ph     = PH_SHRINK;
            linger = 0;
          end
        end
        PH_SHRINK: begin
          if (mirror_len == 0) linger++;
          if (linger > 5) begin
            ph       = PH_MIX;
            linger   = 0;
            mix_left = 40;
          end
        end
        default: begin
          mix_left--;
          if (mix_left <= 0) ph = PH_GROW;
        end
      endcase
      pick_random(ph, item);
      send_item(item);
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (pending_replies.size() != 0) begin
      fault_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_replies.size());
    end
    $display("Sent %0d requests and checked %0d results; peak list length %0d.",
             items_sent, replies_seen, peak_len);
    $display("Status counts: ok %0d, full %0d, empty %0d, bad position %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/bale_pkg.sv
hdl/bale_cell.sv
hdl/bale_ctrl.sv
hdl/bounded_array_list_engine.sv
hdl/bale_checker.sv
test/tb_top.sv
